// ===== rtl/periodic_task_table_scheduler_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the periodic task table scheduler
// Clocked implication checks with a synchronous reset guard.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TABLE_SCHEDULER_CORE_MACROS_SVH
`define PERIODIC_TASK_TABLE_SCHEDULER_CORE_MACROS_SVH

// same-cycle implication
`define PTTS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptts check failed");

// next-cycle implication
`define PTTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptts check failed");

`endif

// ===== rtl/ptts_pkg.sv =====
// ---------------------------------------------------------------------------
// ptts_pkg
// Types and constants shared by the periodic task table scheduler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptts_pkg;

   localparam int SLOTS_DEFAULT       = 8;
   localparam int COUNT_WIDTH_DEFAULT = 16;
   localparam int MAX_RESULTS         = 8;
   localparam int TAG_W               = 16;
   localparam int FIELD_W             = 16;
   localparam int SLOT_OUT_W          = 3;

   typedef enum logic [1:0] {
      FUNC_ADD      = 2'd0,
      FUNC_DELETE   = 2'd1,
      FUNC_TICK     = 2'd2,
      FUNC_DISPATCH = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      func_type               func;
      logic [SLOT_OUT_W-1:0]  slot_index;
      logic [TAG_W-1:0]       task_tag;
      logic [FIELD_W-1:0]     start_delay;
      logic [FIELD_W-1:0]     run_period;
   } req_type;

   typedef struct packed {
      logic                   status;
      logic [SLOT_OUT_W-1:0]  slot_out;
      logic                   run_valid;
      logic [TAG_W-1:0]       run_tag;
      logic                   last_result;
      logic                   long_task_error;
   } rsp_type;

   // control handed to the head unit for the slot now at the ring head
   typedef struct packed {
      func_type func;
      logic     target;   // delete: this slot is the one named
      logic     allow;    // add: no slot taken yet; dispatch: room for a result
   } head_ctl_type;

endpackage

// ===== rtl/periodic_task_table_scheduler_core.sv =====
// ---------------------------------------------------------------------------
// periodic_task_table_scheduler_core
// Task slot table kept in a ring of cells that turns once per item.
// ---------------------------------------------------------------------------
// Each item sweeps the ring: busy through the sweep and the finish state, next
// item accepted once back in idle; a new item waits until the last is through.
// The final result is registered from the finish state; dispatch results
// before it appear during the sweep, one per ready slot.
// Sweep length is set by the slot ring passing one slot per cycle.
// Synchronous reset empties the table and clears the overrun flag.
`timescale 1ns / 1ps
`include "periodic_task_table_scheduler_core_macros.svh"

module periodic_task_table_scheduler_core #(
   parameter int SLOTS       = ptts_pkg::SLOTS_DEFAULT,
   parameter int COUNT_WIDTH = ptts_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ptts_pkg::req_type req_item,
   output logic              rsp_valid,
   output ptts_pkg::rsp_type rsp_item
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int NW = $clog2(ptts_pkg::MAX_RESULTS + 1);

   ptts_pkg::state_type state_ff, state_in;
   ptts_pkg::req_type   req_ff, req_in;
   logic [IW-1:0]       step_ff, step_in;
   logic                found_ff, found_in;
   logic [ptts_pkg::SLOT_OUT_W-1:0] found_slot_ff, found_slot_in;
   logic [NW-1:0]       n_ff, n_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [ptts_pkg::SLOT_OUT_W-1:0] pend_slot_ff, pend_slot_in;
   logic [ptts_pkg::TAG_W-1:0]      pend_tag_ff, pend_tag_in;
   logic [1:0]          ticks_ff, ticks_in;
   logic                overrun_ff, overrun_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ptts_pkg::rsp_type   rsp_item_ff, rsp_item_in;

   logic                       used_q   [SLOTS];
   logic [ptts_pkg::TAG_W-1:0] tag_q    [SLOTS];
   logic [COUNT_WIDTH-1:0]     delay_q  [SLOTS];
   logic [COUNT_WIDTH-1:0]     period_q [SLOTS];
   logic                       ready_q  [SLOTS];

   logic                       head_used, head_ready, head_hit;
   logic [ptts_pkg::TAG_W-1:0] head_tag;
   logic [COUNT_WIDTH-1:0]     head_delay, head_period;
   ptts_pkg::head_ctl_type     head_ctl;
   logic                       shift_en;
   logic                       accept;

   assign accept   = start && (state_ff == ptts_pkg::ST_IDLE);
   assign shift_en = (state_ff == ptts_pkg::ST_RUN);

   for (genvar i = 0; i < SLOTS; i++) begin : g_ring
      logic                       used_d, ready_d;
      logic [ptts_pkg::TAG_W-1:0] tag_d;
      logic [COUNT_WIDTH-1:0]     delay_d, period_d;
      if (i == SLOTS - 1) begin : g_tail
         assign used_d   = head_used;
         assign tag_d    = head_tag;
         assign delay_d  = head_delay;
         assign period_d = head_period;
         assign ready_d  = head_ready;
      end else begin : g_mid
         assign used_d   = used_q[i+1];
         assign tag_d    = tag_q[i+1];
         assign delay_d  = delay_q[i+1];
         assign period_d = period_q[i+1];
         assign ready_d  = ready_q[i+1];
      end
      ptts_cell #(.COUNT_WIDTH(COUNT_WIDTH)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .used_d   (used_d),
         .tag_d    (tag_d),
         .delay_d  (delay_d),
         .period_d (period_d),
         .ready_d  (ready_d),
         .used_q   (used_q[i]),
         .tag_q    (tag_q[i]),
         .delay_q  (delay_q[i]),
         .period_q (period_q[i]),
         .ready_q  (ready_q[i])
      );
   end

   always_comb begin
      head_ctl.func   = req_ff.func;
      head_ctl.target = (32'(req_ff.slot_index) == 32'(step_ff));
      head_ctl.allow  = (req_ff.func == ptts_pkg::FUNC_ADD) ? !found_ff
                      : (n_ff < NW'(ptts_pkg::MAX_RESULTS));
   end

   ptts_head #(.COUNT_WIDTH(COUNT_WIDTH)) u_head (
      .ctl        (head_ctl),
      .new_tag    (req_ff.task_tag),
      .new_delay  (COUNT_WIDTH'(req_ff.start_delay)),
      .new_period (COUNT_WIDTH'(req_ff.run_period)),
      .used_i     (used_q[0]),
      .tag_i      (tag_q[0]),
      .delay_i    (delay_q[0]),
      .period_i   (period_q[0]),
      .ready_i    (ready_q[0]),
      .used_o     (head_used),
      .tag_o      (head_tag),
      .delay_o    (head_delay),
      .period_o   (head_period),
      .ready_o    (head_ready),
      .hit        (head_hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ptts_pkg::ST_IDLE;
         step_ff       <= '0;
         found_ff      <= 1'b0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         ticks_ff      <= '0;
         overrun_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         found_ff      <= found_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         ticks_ff      <= ticks_in;
         overrun_ff    <= overrun_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      found_slot_ff <= found_slot_in;
      pend_slot_ff  <= pend_slot_in;
      pend_tag_ff   <= pend_tag_in;
      rsp_item_ff   <= rsp_item_in;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      step_in       = step_ff;
      found_in      = found_ff;
      found_slot_in = found_slot_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_tag_in   = pend_tag_ff;
      ticks_in      = ticks_ff;
      overrun_in    = overrun_ff;
      rsp_valid_in  = 1'b0;
      rsp_item_in   = '0;
      rsp_item_in.long_task_error = overrun_ff;
      case (state_ff)
         ptts_pkg::ST_IDLE: begin
            if (accept) begin
               req_in        = req_item;
               step_in       = '0;
               found_in      = 1'b0;
               n_in          = '0;
               pend_valid_in = 1'b0;
               state_in      = ptts_pkg::ST_RUN;
            end
         end
         ptts_pkg::ST_RUN: begin
            if (head_hit) begin
               if (req_ff.func == ptts_pkg::FUNC_DISPATCH) begin
                  // hold this task; release the one held before it
                  if (pend_valid_ff) begin
                     rsp_valid_in          = 1'b1;
                     rsp_item_in.slot_out  = pend_slot_ff;
                     rsp_item_in.run_valid = 1'b1;
                     rsp_item_in.run_tag   = pend_tag_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = ptts_pkg::SLOT_OUT_W'(step_ff);
                  pend_tag_in   = tag_q[0];
                  n_in          = n_ff + NW'(1);
               end else begin
                  found_in      = 1'b1;
                  found_slot_in = ptts_pkg::SLOT_OUT_W'(step_ff);
               end
            end
            if (step_ff == IW'(SLOTS - 1)) begin
               state_in = ptts_pkg::ST_FINISH;
            end else begin
               step_in = step_ff + IW'(1);
            end
         end
         ptts_pkg::ST_FINISH: begin
            rsp_valid_in            = 1'b1;
            rsp_item_in.last_result = 1'b1;
            case (req_ff.func)
               ptts_pkg::FUNC_ADD: begin
                  rsp_item_in.status   = !found_ff;
                  rsp_item_in.slot_out = found_ff ? found_slot_ff : '0;
               end
               ptts_pkg::FUNC_DELETE: begin
                  rsp_item_in.status   = !found_ff;
                  rsp_item_in.slot_out = req_ff.slot_index;
               end
               ptts_pkg::FUNC_TICK: begin
                  if (ticks_ff != 2'd0) begin
                     overrun_in = 1'b1;
                  end
                  if (ticks_ff != 2'd3) begin
                     ticks_in = ticks_ff + 2'd1;
                  end
                  rsp_item_in.long_task_error = overrun_in;
               end
               ptts_pkg::FUNC_DISPATCH: begin
                  ticks_in = '0;
                  if (pend_valid_ff) begin
                     rsp_item_in.slot_out  = pend_slot_ff;
                     rsp_item_in.run_valid = 1'b1;
                     rsp_item_in.run_tag   = pend_tag_ff;
                  end
               end
               default: begin
                  rsp_item_in.status = 1'b0;
               end
            endcase
            pend_valid_in = 1'b0;
            state_in      = ptts_pkg::ST_IDLE;
         end
         default: begin
            state_in = ptts_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ptts_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   `PTTS_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `PTTS_ASSERT_NEXT(a_last_gap, clock, reset, rsp_valid && rsp_item.last_result, !rsp_valid)
   `PTTS_ASSERT_SAME(a_run_clean, clock, reset, rsp_valid && rsp_item.run_valid, !rsp_item.status)
   `PTTS_ASSERT_SAME(a_count_cap, clock, reset, busy, n_ff <= NW'(ptts_pkg::MAX_RESULTS))

endmodule

// ===== rtl/ptts_cell.sv =====
// ---------------------------------------------------------------------------
// ptts_cell
// One task slot of the rotating slot ring; loads its neighbor when shifting.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptts_cell #(
   parameter int COUNT_WIDTH = ptts_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        shift_en,
   input  logic                        used_d,
   input  logic [ptts_pkg::TAG_W-1:0]  tag_d,
   input  logic [COUNT_WIDTH-1:0]      delay_d,
   input  logic [COUNT_WIDTH-1:0]      period_d,
   input  logic                        ready_d,
   output logic                        used_q,
   output logic [ptts_pkg::TAG_W-1:0]  tag_q,
   output logic [COUNT_WIDTH-1:0]      delay_q,
   output logic [COUNT_WIDTH-1:0]      period_q,
   output logic                        ready_q
);

   logic                       used_ff;
   logic                       ready_ff;
   logic [ptts_pkg::TAG_W-1:0] tag_ff;
   logic [COUNT_WIDTH-1:0]     delay_ff;
   logic [COUNT_WIDTH-1:0]     period_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         ready_ff <= 1'b0;
      end else if (shift_en) begin
         used_ff  <= used_d;
         ready_ff <= ready_d;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         tag_ff    <= tag_d;
         delay_ff  <= delay_d;
         period_ff <= period_d;
      end
   end

   assign used_q   = used_ff;
   assign ready_q  = ready_ff;
   assign tag_q    = tag_ff;
   assign delay_q  = delay_ff;
   assign period_q = period_ff;

endmodule

// ===== rtl/ptts_head.sv =====
// ---------------------------------------------------------------------------
// ptts_head
// Applies the current operation to the slot leaving the ring head.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptts_head #(
   parameter int COUNT_WIDTH = ptts_pkg::COUNT_WIDTH_DEFAULT
) (
   input  ptts_pkg::head_ctl_type      ctl,
   input  logic [ptts_pkg::TAG_W-1:0]  new_tag,
   input  logic [COUNT_WIDTH-1:0]      new_delay,
   input  logic [COUNT_WIDTH-1:0]      new_period,
   input  logic                        used_i,
   input  logic [ptts_pkg::TAG_W-1:0]  tag_i,
   input  logic [COUNT_WIDTH-1:0]      delay_i,
   input  logic [COUNT_WIDTH-1:0]      period_i,
   input  logic                        ready_i,
   output logic                        used_o,
   output logic [ptts_pkg::TAG_W-1:0]  tag_o,
   output logic [COUNT_WIDTH-1:0]      delay_o,
   output logic [COUNT_WIDTH-1:0]      period_o,
   output logic                        ready_o,
   output logic                        hit
);

   always_comb begin
      used_o   = used_i;
      tag_o    = tag_i;
      delay_o  = delay_i;
      period_o = period_i;
      ready_o  = ready_i;
      hit      = 1'b0;
      case (ctl.func)
         ptts_pkg::FUNC_ADD: begin
            if (ctl.allow && !used_i) begin
               used_o   = 1'b1;
               tag_o    = new_tag;
               delay_o  = new_delay;
               period_o = new_period;
               ready_o  = 1'b0;
               hit      = 1'b1;
            end
         end
         ptts_pkg::FUNC_DELETE: begin
            if (ctl.target && used_i) begin
               used_o   = 1'b0;
               tag_o    = '0;
               delay_o  = '0;
               period_o = '0;
               ready_o  = 1'b0;
               hit      = 1'b1;
            end
         end
         ptts_pkg::FUNC_TICK: begin
            if (used_i) begin
               if (delay_i == '0) begin
                  ready_o = 1'b1;
                  delay_o = period_i;
               end
               if (delay_o != '0) begin
                  delay_o = delay_o - COUNT_WIDTH'(1);
               end
            end
         end
         ptts_pkg::FUNC_DISPATCH: begin
            if (ctl.allow && used_i && ready_i) begin
               ready_o = 1'b0;
               hit     = 1'b1;
               if (period_i == '0) begin
                  used_o   = 1'b0;
                  tag_o    = '0;
                  delay_o  = '0;
                  period_o = '0;
               end
            end
         end
         default: begin
            hit = 1'b0;
         end
      endcase
   end

endmodule
